[rtl/mwpo_pkg.sv]
package mwpo_pkg;

   localparam int PHASE_BITS       = 32;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_ROM_IDX_BITS = SINE_IDX_BITS + 1;
   localparam int SINE_VALUE_BITS  = 15;

   localparam int FREQ_BITS     = 24;
   localparam int SAMPLE_BITS   = 16;
   localparam int WAVE_BITS     = 3;
   localparam int STEP_BITS     = 41;
   localparam int STEP_LO_BITS  = 24;
   localparam int STEP_HI_BITS  = STEP_BITS - STEP_LO_BITS;
   localparam int PROD_BITS     = 48;
   localparam int PROD_HI_BITS  = PROD_BITS - STEP_LO_BITS;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = STEP_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVEFORM    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_PER_HZ = 2'd1;

   localparam logic [STEP_BITS-1:0] STEP_RESET = 41'd22906492;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   // front register + queue + output register
   localparam int PIPE_CAPACITY   = QUEUE_DEPTH + 2;
   localparam int FLIGHT_CNT_BITS = $clog2(PIPE_CAPACITY + 2);

   typedef enum logic [WAVE_BITS-1:0] {
      WAVE_SINE     = 3'd0,
      WAVE_SQUARE   = 3'd1,
      WAVE_SAW_FALL = 3'd2,
      WAVE_SAW_RISE = 3'd3,
      WAVE_TRIANGLE = 3'd4
   } waveform_type;

   typedef struct packed {
      logic                  valid;
      logic [PHASE_BITS-1:0] inc;
   } inc_item_type;

   typedef logic [SINE_VALUE_BITS-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   localparam longint Q30_ONE      = 64'sd1073741824;
   localparam longint Q30_HALF_PI  = 64'sd1686629713;
   localparam longint SINE_DEPTH_L = longint'(SINE_TABLE_DEPTH);

   // taylor terms k = 1..9, each divided by (2k)(2k+1)
   function automatic longint sine_q30(longint theta);
      longint sq;
      longint term;
      longint sum;
      sq   = (theta * theta) / Q30_ONE;
      term = theta;
      sum  = theta;
      term = -((term * sq) / Q30_ONE) / 64'sd6;
      sum  = sum + term;
      term = -((term * sq) / Q30_ONE) / 64'sd20;
      sum  = sum + term;
      term = -((term * sq) / Q30_ONE) / 64'sd42;
      sum  = sum + term;
      term = -((term * sq) / Q30_ONE) / 64'sd72;
      sum  = sum + term;
      term = -((term * sq) / Q30_ONE) / 64'sd110;
      sum  = sum + term;
      term = -((term * sq) / Q30_ONE) / 64'sd156;
      sum  = sum + term;
      term = -((term * sq) / Q30_ONE) / 64'sd210;
      sum  = sum + term;
      term = -((term * sq) / Q30_ONE) / 64'sd272;
      sum  = sum + term;
      term = -((term * sq) / Q30_ONE) / 64'sd342;
      sum  = sum + term;
      return sum;
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint       theta;
      longint       s;
      longint       v;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         theta = (Q30_HALF_PI * longint'(i)) / SINE_DEPTH_L;
         s     = sine_q30(theta);
         if (s < 0) begin
            s = 0;
         end
         v = (s + 16384) / 32768;
         if (v > 32767) begin
            v = 32767;
         end
         rom[i] = SINE_VALUE_BITS'(v);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

[rtl/mwpo_ifs.sv]
interface mwpo_req_if;
   import mwpo_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [FREQ_BITS-1:0] frequency;
   modport source (output valid, output frequency, input ready);
   modport sink (input valid, input frequency, output ready);
endinterface

interface mwpo_rsp_if;
   import mwpo_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface mwpo_csr_if;
   import mwpo_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/mwpo_front.sv]
module mwpo_front (
   input  logic                          clock,
   input  logic                          reset,
   mwpo_req_if.sink                      req_if,
   input  logic [mwpo_pkg::STEP_BITS-1:0] step_per_hz,
   output mwpo_pkg::inc_item_type        push,
   input  logic                          push_ready
);
   import mwpo_pkg::*;

   logic                           valid_ff;
   logic signed [PROD_BITS-1:0]    pp_lo_ff;
   logic signed [PROD_BITS-1:0]    pp_lo_in;
   logic [PROD_HI_BITS-1:0]        pp_hi_ff;
   logic [PROD_HI_BITS-1:0]        pp_hi_in;
   logic signed [PROD_BITS-1:0]    freq_ext;
   logic signed [PROD_BITS-1:0]    step_lo_ext;
   logic [PROD_HI_BITS-1:0]        step_hi_ext;
   logic [PROD_BITS-1:0]           sum;
   logic                           accept;

   assign req_if.ready = !valid_ff || push_ready;
   assign accept       = req_if.valid && req_if.ready;

   // product split at bit 24 of the step, kept modulo 2^48
   assign freq_ext    = PROD_BITS'(req_if.frequency);
   assign step_lo_ext = $signed({{(PROD_BITS - STEP_LO_BITS){1'b0}},
                                 step_per_hz[STEP_LO_BITS-1:0]});
   assign step_hi_ext = PROD_HI_BITS'(step_per_hz[STEP_BITS-1:STEP_LO_BITS]);
   assign pp_lo_in    = freq_ext * step_lo_ext;
   assign pp_hi_in    = PROD_HI_BITS'(req_if.frequency) * step_hi_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         valid_ff <= req_if.valid;
      end
      if (accept) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
      end
   end

   // floor shift of the signed product is just its upper bits
   assign sum        = pp_lo_ff + {pp_hi_ff, {STEP_LO_BITS{1'b0}}};
   assign push.valid = valid_ff;
   assign push.inc   = sum[PROD_BITS-1 -: PHASE_BITS];

endmodule

[rtl/mwpo_queue.sv]
module mwpo_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  mwpo_pkg::inc_item_type push,
   output logic                   push_ready,
   output mwpo_pkg::inc_item_type pop,
   input  logic                   pop_ready
);
   import mwpo_pkg::*;

   logic [PHASE_BITS-1:0]     slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic [QUEUE_CNT_BITS-1:0] count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign do_push    = push.valid && push_ready;
   assign pop.valid  = count_ff != '0;
   assign pop.inc    = slot_ff[rd_ptr_ff];
   assign do_pop     = pop.valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.inc;
      end
   end

endmodule

[rtl/mwpo_back.sv]
module mwpo_back (
   input  logic                   clock,
   input  logic                   reset,
   input  mwpo_pkg::inc_item_type pop,
   output logic                   pop_ready,
   input  mwpo_pkg::waveform_type waveform,
   mwpo_rsp_if.source             rsp_if
);
   import mwpo_pkg::*;

   logic                          valid_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic [PHASE_BITS-1:0]         phase_ff;
   logic                          fire;

   logic [1:0]                    quad;
   logic [SINE_IDX_BITS-1:0]      idx;
   logic [SINE_ROM_IDX_BITS-1:0]  rom_idx;
   logic [SAMPLE_BITS-1:0]        sine_pos;
   logic [SAMPLE_BITS-1:0]        sine_val;
   logic [SAMPLE_BITS-1:0]        x;
   logic [SAMPLE_BITS:0]          y;
   logic [SAMPLE_BITS:0]          tri_abs;
   logic [SAMPLE_BITS-1:0]        square_val;
   logic [SAMPLE_BITS-1:0]        fall_val;
   logic [SAMPLE_BITS-1:0]        rise_val;
   logic [SAMPLE_BITS-1:0]        tri_val;

   assign pop_ready = !valid_ff || rsp_if.ready;
   assign fire      = pop.valid && pop_ready;

   // sine: quarter table, mirrored in odd quadrants, negated in the lower half
   assign quad     = phase_ff[PHASE_BITS-1 -: 2];
   assign idx      = phase_ff[PHASE_BITS-3 -: SINE_IDX_BITS];
   assign rom_idx  = quad[0] ? (SINE_ROM_IDX_BITS'(SINE_TABLE_DEPTH) - {1'b0, idx})
                             : {1'b0, idx};
   assign sine_pos = {1'b0, SINE_ROM[rom_idx]};
   assign sine_val = quad[1] ? (~sine_pos + 1'b1) : sine_pos;

   assign square_val = (!phase_ff[PHASE_BITS-1] || (phase_ff[PHASE_BITS-2:0] == '0))
                       ? SAMPLE_MAX : SAMPLE_MIN;

   assign x        = phase_ff[PHASE_BITS-1 -: SAMPLE_BITS];
   assign fall_val = (x == '0) ? SAMPLE_MAX : (SAMPLE_MIN - x);
   assign rise_val = x ^ SAMPLE_MIN;

   // |y - 65536| - 32768, where only |y - 65536| == 65536 saturates
   assign y       = phase_ff[PHASE_BITS-1 -: SAMPLE_BITS + 1];
   assign tri_abs = y[SAMPLE_BITS] ? {1'b0, y[SAMPLE_BITS-1:0]}
                                   : ({1'b1, {SAMPLE_BITS{1'b0}}}
                                      - {1'b0, y[SAMPLE_BITS-1:0]});
   assign tri_val = tri_abs[SAMPLE_BITS] ? SAMPLE_MAX
                                         : (tri_abs[SAMPLE_BITS-1:0] ^ SAMPLE_MIN);

   always_comb begin
      case (waveform)
         WAVE_SINE:     sample_in = sine_val;
         WAVE_SQUARE:   sample_in = square_val;
         WAVE_SAW_FALL: sample_in = fall_val;
         WAVE_SAW_RISE: sample_in = rise_val;
         WAVE_TRIANGLE: sample_in = tri_val;
         default:       sample_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= '0;
      end else begin
         if (pop_ready) begin
            valid_ff <= pop.valid;
         end
         if (fire) begin
            phase_ff <= phase_ff + pop.inc;
         end
      end
      if (fire) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_if.valid  = valid_ff;
   assign rsp_if.sample = sample_ff;

endmodule

[rtl/multi_waveform_phase_oscillator.sv]
// Phase-accumulator oscillator. Every req item is one sample tick with a signed
// frequency in 1/256 Hz; it yields one rsp item, a Q1.15 sample of the selected
// waveform taken at the current phase, after which the phase advances by
// (frequency * step_per_hz) >> 16, wrapping modulo a full cycle. One item is taken
// per clock when rsp is not stalled; each item passes the partial-product register,
// the two-entry increment queue and the output register. The sustained rate is set
// by the single 32-bit phase add in the back end. Registers are written through csr:
// index 0 waveform (0 sine, 1 square, 2 falling saw, 3 rising saw, 4 triangle,
// other codes give zero), index 1 step_per_hz; write them only with no item in
// flight. Other indexes are ignored.
module multi_waveform_phase_oscillator (
   input logic        clock,
   input logic        reset,
   mwpo_req_if.sink   req_if,
   mwpo_rsp_if.source rsp_if,
   mwpo_csr_if.sink   csr_if
);
   import mwpo_pkg::*;

   waveform_type          waveform_ff;
   logic [STEP_BITS-1:0]  step_ff;
   inc_item_type          push;
   inc_item_type          pop;
   logic                  push_ready;
   logic                  pop_ready;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff <= WAVE_SINE;
         step_ff     <= STEP_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_WAVEFORM:    waveform_ff <= waveform_type'(csr_if.data[WAVE_BITS-1:0]);
            CSR_STEP_PER_HZ: step_ff     <= csr_if.data[STEP_BITS-1:0];
            default:         ;
         endcase
      end
   end

   mwpo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .step_per_hz (step_ff),
      .push        (push),
      .push_ready  (push_ready)
   );

   mwpo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   mwpo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_ready (pop_ready),
      .waveform  (waveform_ff),
      .rsp_if    (rsp_if)
   );

endmodule

[rtl/mwpo_checker.sv]
module mwpo_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [mwpo_pkg::SAMPLE_BITS-1:0] rsp_sample
);
   import mwpo_pkg::*;

   logic [FLIGHT_CNT_BITS-1:0] in_flight_ff;
   logic [FLIGHT_CNT_BITS-1:0] in_flight_in;
   logic                       req_acc;
   logic                       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      in_flight_in = in_flight_ff;
      if (req_acc && !rsp_acc) begin
         in_flight_in = in_flight_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         in_flight_in = in_flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // every sample belongs to an item taken earlier
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (in_flight_ff != '0))
      else $error("rsp item without an outstanding req item");

   a_bounded_flight: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= FLIGHT_CNT_BITS'(PIPE_CAPACITY))
      else $error("more items in flight than the pipeline holds");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample)))
      else $error("stalled rsp item dropped or changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind multi_waveform_phase_oscillator mwpo_checker u_mwpo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_sample (rsp_if.sample)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import mwpo_pkg::*;

   // csr indexes the block does not decode
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_TICKS = 70;

   logic clock = 1'b0;
   logic reset;

   mwpo_req_if req_ch ();
   mwpo_rsp_if rsp_ch ();
   mwpo_csr_if csr_ch ();

   multi_waveform_phase_oscillator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the oscillator
   logic [PHASE_BITS-1:0]        tone_phase = '0;
   logic [WAVE_BITS-1:0]         wave_sel   = WAVE_SINE;
   logic [STEP_BITS-1:0]         hz_step    = STEP_RESET;
   int                           sine_lut [0:SINE_TABLE_DEPTH];

   logic signed [FREQ_BITS-1:0]   tick_backlog [$];
   logic signed [SAMPLE_BITS-1:0] expected_samples [$];
   logic signed [SAMPLE_BITS-1:0] want_sample;
   int                            ticks_sent   = 0;
   int                            samples_seen = 0;
   int                            errors       = 0;
   bit                            no_gaps      = 1'b0;

   // ten-term taylor series in q30
   function automatic longint taylor_sin_q30(input longint angle);
      longint ang_sq;
      longint part;
      longint total;
      ang_sq = (angle * angle) / 64'sd1073741824;
      part   = angle;
      total  = angle;
      for (int n = 1; n <= 9; n++) begin
         part  = -((part * ang_sq) / 64'sd1073741824) / longint'((2 * n) * (2 * n + 1));
         total = total + part;
      end
      return total;
   endfunction

   function automatic int sample_at(input logic [PHASE_BITS-1:0] p,
                                    input logic [WAVE_BITS-1:0] sel);
      int coarse;
      int fine;
      int idx;
      int v;
      coarse = p >> 16;
      fine   = p >> 15;
      case (sel)
         WAVE_SINE: begin
            idx = int'(p[29:22]);
            if (p[30]) begin
               idx = SINE_TABLE_DEPTH - idx;
            end
            v = p[31] ? -sine_lut[idx] : sine_lut[idx];
         end
         WAVE_SQUARE: begin
            v = (p <= 32'h8000_0000) ? 32767 : -32768;
         end
         WAVE_SAW_FALL: begin
            v = 32768 - coarse;
            if (v > 32767) begin
               v = 32767;
            end
         end
         WAVE_SAW_RISE: begin
            v = coarse - 32768;
         end
         WAVE_TRIANGLE: begin
            v = fine - 65536;
            if (v < 0) begin
               v = -v;
            end
            v = v - 32768;
            if (v > 32767) begin
               v = 32767;
            end
         end
         default: begin
            v = 0;
         end
      endcase
      return v;
   endfunction

   // floor((freq * step) / 2^16), low phase bits kept
   function automatic logic [PHASE_BITS-1:0] phase_inc(input logic signed [FREQ_BITS-1:0] freq,
                                                      input logic [STEP_BITS-1:0] step);
      logic signed [65:0] f_wide;
      logic signed [65:0] s_wide;
      logic signed [65:0] prod;
      f_wide = freq;
      s_wide = {25'd0, step};
      prod   = f_wide * s_wide;
      return prod[47:16];
   endfunction

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (tick_backlog.size() != 0 && (no_gaps || $urandom_range(99) >= 31)) begin
            req_ch.valid     <= 1'b1;
            req_ch.frequency <= tick_backlog.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 31);
      end
   end

   // monitor: check samples, track csr writes and ticks
   always @(posedge clock) begin
      if (reset) begin
         tone_phase = '0;
         wave_sel   = WAVE_SINE;
         hz_step    = STEP_RESET;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_samples.size() == 0) begin
               errors++;
               $display("%0t: unexpected sample, expected none actual %0d", $time,
                        rsp_ch.sample);
            end else begin
               want_sample = expected_samples.pop_front();
               samples_seen++;
               if (rsp_ch.sample !== want_sample) begin
                  errors++;
                  $display("%0t: sample mismatch, expected %0d actual %0d", $time,
                           want_sample, rsp_ch.sample);
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_WAVEFORM:    wave_sel = csr_ch.data[WAVE_BITS-1:0];
               CSR_STEP_PER_HZ: hz_step  = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_samples.push_back(SAMPLE_BITS'(sample_at(tone_phase, wave_sel)));
            tone_phase = tone_phase + phase_inc(req_ch.frequency, hz_step);
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic add_tick(input logic signed [FREQ_BITS-1:0] freq);
      tick_backlog.push_back(freq);
      ticks_sent++;
   endtask

   task automatic drain();
      do @(posedge clock); while (samples_seen != ticks_sent);
   endtask

   // two ticks that land the phase exactly on target
   task automatic steer_phase(input logic [PHASE_BITS-1:0] target);
      logic [PHASE_BITS-1:0] gap;
      gap = target - tone_phase;
      write_reg(CSR_STEP_PER_HZ, 41'd65536);
      add_tick({{8{gap[15]}}, gap[15:0]});
      drain();
      gap = target - tone_phase;
      write_reg(CSR_STEP_PER_HZ, 41'h1_0000_0000);
      add_tick({{8{gap[31]}}, gap[31:16]});
      drain();
   endtask

   function automatic logic signed [FREQ_BITS-1:0] random_frequency();
      int pick;
      int f;
      pick = $urandom_range(99);
      if (pick < 60) begin
         f = $urandom;
      end else if (pick < 80) begin
         f = $urandom_range(4000);
         if ($urandom_range(1)) begin
            f = -f;
         end
      end else if (pick < 90) begin
         case ($urandom_range(4))
            0:       f = 8388607;
            1:       f = -8388608;
            2:       f = 0;
            3:       f = 1;
            default: f = -1;
         endcase
      end else begin
         f = int'($urandom_range(131071)) - 65536;
      end
      return FREQ_BITS'(f);
   endfunction

   function automatic logic [STEP_BITS-1:0] step_for_phase(input int k);
      case (k)
         0: return STEP_RESET;
         1: return '0;
         2: return 41'h100_0000_0000;
         3: return 41'd1;
         4: return '1;
         5: return STEP_BITS'({$urandom, $urandom});
         7: return STEP_BITS'($urandom_range(1 << 26, 1));
         default: return STEP_BITS'({$urandom, $urandom}) % 41'h100_0000_0000 + 41'd1;
      endcase
   endfunction

   initial begin
      logic [WAVE_BITS-1:0] code;
      longint               angle;
      longint               s;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         angle = (64'sd1686629713 * longint'(i)) / longint'(SINE_TABLE_DEPTH);
         s     = taylor_sin_q30(angle);
         if (s < 0) begin
            s = 0;
         end
         s = (s + 16384) / 32768;
         sine_lut[i] = (s > 32767) ? 32767 : int'(s);
      end

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.frequency = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, frequency extremes
      add_tick(24'sd0);
      add_tick(24'sd8388607);
      add_tick(-24'sd8388608);
      add_tick(24'sd1);
      add_tick(-24'sd1);
      add_tick(24'sd0);
      drain();

      // undecoded indexes must leave the settings alone
      write_reg(CSR_SPARE_A, STEP_BITS'({$urandom, $urandom}));
      write_reg(CSR_SPARE_B, STEP_BITS'({$urandom, $urandom}));

      // every waveform code at phase zero
      steer_phase(32'h0000_0000);
      for (int w = 0; w < 2 ** WAVE_BITS; w++) begin
         write_reg(CSR_WAVEFORM, CSR_DATA_BITS'(w));
         add_tick(24'sd0);
         drain();
      end

      // half cycle: square edge and triangle bottom
      steer_phase(32'h8000_0000);
      write_reg(CSR_WAVEFORM, CSR_DATA_BITS'(WAVE_SQUARE));
      add_tick(24'sd0);
      drain();
      write_reg(CSR_WAVEFORM, CSR_DATA_BITS'(WAVE_TRIANGLE));
      add_tick(24'sd0);
      drain();
      write_reg(CSR_STEP_PER_HZ, 41'd65536);
      write_reg(CSR_WAVEFORM, CSR_DATA_BITS'(WAVE_SQUARE));
      add_tick(24'sd1);
      add_tick(24'sd0);
      drain();

      for (int k = 0; k < PHASE_COUNT; k++) begin
         code = (k < 8) ? WAVE_BITS'((k * 3) % 8) : WAVE_BITS'($urandom_range(4));
         write_reg(CSR_WAVEFORM, {38'($urandom), code});
         write_reg(CSR_STEP_PER_HZ, step_for_phase(k));
         no_gaps = (k == 6);
         for (int i = 0; i < PHASE_TICKS; i++) begin
            add_tick(random_frequency());
         end
         drain();
         no_gaps = 1'b0;
      end

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("PASS multi_waveform_phase_oscillator");
      end else begin
         $display("FAIL multi_waveform_phase_oscillator");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL multi_waveform_phase_oscillator");
      $finish;
   end

endmodule
